// File: hw/rtl/contrast_stretch_normalizer_core_macros.svh
// Assertion macros shared by the contrast stretch RTL.
`ifndef CONTRAST_STRETCH_NORMALIZER_CORE_MACROS_SVH
`define CONTRAST_STRETCH_NORMALIZER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CSN_ASSERT_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed: same-cycle implication");
`define CSN_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed: next-cycle implication");
`else
`define CSN_ASSERT_IMPLY(label, clk, rst, cond, expr)
`define CSN_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

// File: hw/rtl/csn_pkg.sv
// Types and constants of the contrast stretch normalizer.
package csn_pkg;

  localparam int CMD_W               = 2;
  localparam int VALUE_W             = 8;
  localparam int QUOT_W              = 8;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [VALUE_W-1:0] LOW_RESET  = 8'hFF;
  localparam logic [VALUE_W-1:0] HIGH_RESET = 8'h00;
  localparam logic [VALUE_W-1:0] OUT_MAX    = 8'hFF;
  localparam logic [VALUE_W-1:0] OUT_MIN    = 8'h00;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_MEASURE = 2'd1,
    CMD_MAP     = 2'd2
  } cmd_t;

  typedef struct packed {
    logic               direct;
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] diff;
    logic [VALUE_W-1:0] span;
  } job_t;

endpackage

// File: hw/rtl/csn_if.sv
// Request and result channel interfaces of the contrast stretch normalizer.
interface csn_in_if;
  logic                       valid;
  logic                       ready;
  logic [csn_pkg::CMD_W-1:0]   cmd;
  logic [csn_pkg::VALUE_W-1:0] channel_value;

  modport source (output valid, output cmd, output channel_value, input ready);
  modport sink   (input valid, input cmd, input channel_value, output ready);
endinterface

interface csn_out_if;
  logic                       valid;
  logic                       ready;
  logic [csn_pkg::VALUE_W-1:0] mapped_value;

  modport source (output valid, output mapped_value, input ready);
  modport sink   (input valid, input mapped_value, output ready);
endinterface

// File: hw/rtl/csn_front.sv
// Front end: accepts requests, tracks the running range, classifies map requests.
module csn_front (
  input  logic          clk,
  input  logic          rst,
  csn_in_if.sink        pixel,
  output logic          push_valid,
  output csn_pkg::job_t push_job,
  input  logic          push_ready
);
  import csn_pkg::*;

  logic [VALUE_W-1:0] low_seen;
  logic [VALUE_W-1:0] high_seen;
  logic               accept;
  cmd_t               cmd;
  logic [VALUE_W-1:0] v;

  assign pixel.ready = push_ready;
  assign accept      = pixel.valid && pixel.ready;
  assign cmd         = cmd_t'(pixel.cmd);
  assign v           = pixel.channel_value;
  assign push_valid  = accept && (cmd == CMD_MAP);

  always_comb begin
    push_job.direct = 1'b1;
    push_job.value  = OUT_MIN;
    push_job.diff   = v - low_seen;
    push_job.span   = high_seen - low_seen;
    priority if (high_seen <= low_seen) begin
      push_job.value = OUT_MIN;
    end else if (v < low_seen) begin
      push_job.value = OUT_MIN;
    end else if (v >= high_seen) begin
      push_job.value = OUT_MAX;
    end else begin
      push_job.direct = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_seen  <= LOW_RESET;
      high_seen <= HIGH_RESET;
    end else if (accept) begin
      if (cmd == CMD_CLEAR) begin
        low_seen  <= LOW_RESET;
        high_seen <= HIGH_RESET;
      end else if (cmd == CMD_MEASURE) begin
        if (v < low_seen) begin
          low_seen <= v;
        end
        if (v > high_seen) begin
          high_seen <= v;
        end
      end
    end
  end

endmodule

// File: hw/rtl/csn_queue.sv
// Small flop-based queue of map jobs between front and back.
module csn_queue #(
  parameter int DEPTH = csn_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  csn_pkg::job_t push_job,
  output logic          push_ready,
  output logic          pop_valid,
  output csn_pkg::job_t pop_job,
  input  logic          pop_ready
);
  import csn_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/csn_back.sv
// Back end: restoring divider for the stretch quotient and the result register.
module csn_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  csn_pkg::job_t job,
  output logic          job_ready,
  csn_out_if.source     result
);
  import csn_pkg::*;

  localparam int STEP_W = $clog2(QUOT_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } back_state_t;

  back_state_t         state;
  logic [STEP_W-1:0]   step;
  logic [VALUE_W-1:0]  rem;
  logic [VALUE_W-1:0]  span;
  logic [QUOT_W-1:0]   quot;
  logic [VALUE_W:0]    rem_dbl;
  logic                ge;
  logic [VALUE_W-1:0]  rem_next;
  logic                out_valid;
  logic [VALUE_W-1:0]  out_data;
  logic                load_out;

  assign job_ready           = (state == ST_IDLE);
  assign rem_dbl             = {rem, 1'b0};
  assign ge                  = (rem_dbl >= {1'b0, span});
  assign rem_next            = ge ? VALUE_W'(rem_dbl - {1'b0, span}) : rem_dbl[VALUE_W-1:0];
  assign load_out            = (state == ST_DONE) && (!out_valid || result.ready);
  assign result.valid        = out_valid;
  assign result.mapped_value = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          step <= '0;
          if (job_valid) begin
            state <= job.direct ? ST_DONE : ST_DIV;
          end
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(QUOT_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && job_valid) begin
      quot <= job.value;
      rem  <= job.diff;
      span <= job.span;
    end else if (state == ST_DIV) begin
      rem  <= rem_next;
      quot <= {quot[QUOT_W-2:0], ge};
    end
    if (load_out) begin
      out_data <= quot;
    end
  end

endmodule

// File: hw/rtl/contrast_stretch_normalizer_core.sv
// Top level of the min-max contrast stretch normalizer on 8-bit channel bytes.
// Clear and measure requests are taken one per cycle while the queue has room and
// update the running minimum and maximum at once. A map request is classified on
// entry against the range at that moment and queued (QUEUE_DEPTH entries); empty,
// flat, below-range, above-range and top-of-range cases resolve directly in the back
// end, others go through an 8-step restoring divider, one quotient bit per cycle. The
// back end takes a new map job only once it is through with the last, while the front
// keeps taking requests until the queue is full. The result register holds a finished
// byte until it is taken.
`include "contrast_stretch_normalizer_core_macros.svh"

module contrast_stretch_normalizer_core #(
  parameter int QUEUE_DEPTH = csn_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  csn_in_if.sink    pixel,
  csn_out_if.source result
);
  import csn_pkg::*;

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic job_valid;
  logic job_ready;
  job_t job;

  csn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  csn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (job_valid),
    .pop_job    (job),
    .pop_ready  (job_ready)
  );

  csn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready),
    .result    (result)
  );

  `CSN_ASSERT_IMPLY(a_map_has_room, clk, rst, push_valid, push_ready)
  `CSN_ASSERT_NEXT(a_back_busy_after_pop, clk, rst, job_valid && job_ready, !job_ready)
  `CSN_ASSERT_IMPLY(a_result_from_busy_back, clk, rst, $rose(result.valid), $past(!job_ready))

endmodule
